// ===== hdl/gbr_pkg.sv =====
// ----------------------------------------------------------------------------
// gbr_pkg
// Shared types and constants of the glyph bitmap rasterizer: field widths,
// request kinds, register indexes and the controller/datapath link structs.
// ----------------------------------------------------------------------------
package gbr_pkg;

    // field widths
    localparam int KIND_W   = 2;
    localparam int ADDR_W   = 12;
    localparam int BYTE_W   = 8;
    localparam int OFFSET_W = 12;
    localparam int SIZE_W   = 4;
    localparam int ADV_W    = 8;
    localparam int DELTA_W  = 8;
    localparam int COORD_W  = 16;
    localparam int CHAR_W   = 8;
    localparam int COLOR_W  = 16;
    localparam int LINE_W   = 8;

    // configuration port
    localparam int APB_AW = 4;
    localparam int APB_DW = 32;
    localparam int REG_IDX_W = 2;

    // request kinds
    localparam logic [KIND_W-1:0] KIND_LOAD_BYTE  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_LOAD_GLYPH = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SET_CURSOR = 2'd2;
    localparam logic [KIND_W-1:0] KIND_DRAW       = 2'd3;

    // register indexes
    localparam logic [REG_IDX_W-1:0] REG_FIRST_CHAR  = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_LAST_CHAR   = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_LINE_HEIGHT = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_TEXT_COLOR  = 2'd3;

    // register reset values
    localparam logic [CHAR_W-1:0]  FIRST_CHAR_RST  = 8'd32;
    localparam logic [CHAR_W-1:0]  LAST_CHAR_RST   = 8'd126;
    localparam logic [LINE_W-1:0]  LINE_HEIGHT_RST = 8'd0;
    localparam logic [COLOR_W-1:0] TEXT_COLOR_RST  = 16'hFFFF;

    typedef struct packed {
        logic [CHAR_W-1:0]  first_char;
        logic [CHAR_W-1:0]  last_char;
        logic [LINE_W-1:0]  line_height;
        logic [COLOR_W-1:0] text_color;
    } cfg_t;

    typedef struct packed {
        logic [OFFSET_W-1:0] offset;
        logic [SIZE_W-1:0]   width;
        logic [SIZE_W-1:0]   height;
        logic [ADV_W-1:0]    advance;
        logic [DELTA_W-1:0]  dx;
        logic [DELTA_W-1:0]  dy;
    } glyph_entry_t;

    // controller to datapath
    typedef struct packed {
        logic load_byte;
        logic load_glyph;
        logic set_cursor;
        logic start_draw;
        logic setup;
        logic reduce_step;
        logic fetch;
        logic scan_step;
        logic flush;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic code_hit;
        logic size_zero;
        logic addr_big;
        logic bit_set;
        logic pend_valid;
        logic out_free;
        logic scan_last;
        logic byte_end;
    } dp_stat_t;

endpackage

// ===== hdl/gbr_in_if.sv =====
// ----------------------------------------------------------------------------
// gbr_in_if
// Request channel: valid/ready handshake with the request fields.
// ----------------------------------------------------------------------------
interface gbr_in_if;
    import gbr_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [KIND_W-1:0]         kind;
    logic [ADDR_W-1:0]         address;
    logic [BYTE_W-1:0]         byte_data;
    logic [OFFSET_W-1:0]       glyph_offset;
    logic [SIZE_W-1:0]         glyph_width;
    logic [SIZE_W-1:0]         glyph_height;
    logic [ADV_W-1:0]          glyph_advance;
    logic signed [DELTA_W-1:0] glyph_dx;
    logic signed [DELTA_W-1:0] glyph_dy;
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic [CHAR_W-1:0]         char_code;

    modport source (
        output valid, kind, address, byte_data, glyph_offset, glyph_width,
               glyph_height, glyph_advance, glyph_dx, glyph_dy, pos_x, pos_y,
               char_code,
        input  ready
    );

    modport sink (
        input  valid, kind, address, byte_data, glyph_offset, glyph_width,
               glyph_height, glyph_advance, glyph_dx, glyph_dy, pos_x, pos_y,
               char_code,
        output ready
    );

endinterface

// ===== hdl/gbr_out_if.sv =====
// ----------------------------------------------------------------------------
// gbr_out_if
// Result channel: valid/ready handshake with the pixel write fields.
// ----------------------------------------------------------------------------
interface gbr_out_if;
    import gbr_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] pixel_x;
    logic signed [COORD_W-1:0] pixel_y;
    logic [COLOR_W-1:0]        pixel_color;
    logic                      pixel_valid;
    logic                      last;
    logic signed [COORD_W-1:0] next_cursor_x;

    modport source (
        output valid, pixel_x, pixel_y, pixel_color, pixel_valid, last,
               next_cursor_x,
        input  ready
    );

    modport sink (
        input  valid, pixel_x, pixel_y, pixel_color, pixel_valid, last,
               next_cursor_x,
        output ready
    );

endinterface

// ===== hdl/gbr_regs.sv =====
// ----------------------------------------------------------------------------
// gbr_regs
// APB-style configuration registers: first/last character, line height and
// text color, with read back.
// ----------------------------------------------------------------------------
module gbr_regs (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [gbr_pkg::APB_AW-1:0] paddr,
    input  logic [gbr_pkg::APB_DW-1:0] pwdata,
    output logic [gbr_pkg::APB_DW-1:0] prdata,
    output logic                       pready,
    output gbr_pkg::cfg_t              cfg
);
    import gbr_pkg::*;

    cfg_t                 cfg_reg;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[APB_AW-1:2];
    assign wr_en   = psel && penable && pwrite && pready;
    assign cfg     = cfg_reg;

    // register write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.first_char  <= FIRST_CHAR_RST;
            cfg_reg.last_char   <= LAST_CHAR_RST;
            cfg_reg.line_height <= LINE_HEIGHT_RST;
            cfg_reg.text_color  <= TEXT_COLOR_RST;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_FIRST_CHAR:  cfg_reg.first_char  <= pwdata[CHAR_W-1:0];
                REG_LAST_CHAR:   cfg_reg.last_char   <= pwdata[CHAR_W-1:0];
                REG_LINE_HEIGHT: cfg_reg.line_height <= pwdata[LINE_W-1:0];
                REG_TEXT_COLOR:  cfg_reg.text_color  <= pwdata[COLOR_W-1:0];
                default:         ;
            endcase
        end
    end

    // read back
    always_comb
    begin
        case (reg_idx)
            REG_FIRST_CHAR:  prdata = APB_DW'(cfg_reg.first_char);
            REG_LAST_CHAR:   prdata = APB_DW'(cfg_reg.last_char);
            REG_LINE_HEIGHT: prdata = APB_DW'(cfg_reg.line_height);
            REG_TEXT_COLOR:  prdata = APB_DW'(cfg_reg.text_color);
            default:         prdata = '0;
        endcase
    end

endmodule

// ===== hdl/gbr_ctrl.sv =====
// ----------------------------------------------------------------------------
// gbr_ctrl
// Controller: takes requests, sequences glyph lookup, offset wrap, byte fetch,
// bit scan and the final result of a draw.
// ----------------------------------------------------------------------------
module gbr_ctrl (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic [gbr_pkg::KIND_W-1:0] in_kind,
    output logic                       in_ready,
    input  gbr_pkg::dp_stat_t          stat,
    output gbr_pkg::dp_cmd_t           cmd
);
    import gbr_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_GLYPH  = 3'd1;
    localparam logic [2:0] S_REDUCE = 3'd2;
    localparam logic [2:0] S_FETCH  = 3'd3;
    localparam logic [2:0] S_SCAN   = 3'd4;
    localparam logic [2:0] S_FLUSH  = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       step_ok;

    assign in_ready = (state_reg == S_IDLE);

    // a set bit with a pixel already held needs room in the output register
    assign step_ok = !(stat.bit_set && stat.pend_valid) || stat.out_free;

    // next state and commands
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    case (in_kind)
                        KIND_LOAD_BYTE:  cmd.load_byte  = 1'b1;
                        KIND_LOAD_GLYPH: cmd.load_glyph = 1'b1;
                        KIND_SET_CURSOR: cmd.set_cursor = 1'b1;
                        KIND_DRAW:
                        begin
                            cmd.start_draw = 1'b1;
                            state_next     = stat.code_hit ? S_GLYPH : S_FLUSH;
                        end
                        default: ;
                    endcase
                end
            end
            S_GLYPH:
            begin
                cmd.setup  = 1'b1;
                state_next = S_REDUCE;
            end
            S_REDUCE:
            begin
                if (stat.size_zero)
                begin
                    state_next = S_FLUSH;
                end
                else if (stat.addr_big)
                begin
                    cmd.reduce_step = 1'b1;
                end
                else
                begin
                    cmd.fetch  = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_FETCH:
            begin
                cmd.fetch  = 1'b1;
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (step_ok)
                begin
                    cmd.scan_step = 1'b1;
                    if (stat.scan_last)
                    begin
                        state_next = S_FLUSH;
                    end
                    else if (stat.byte_end)
                    begin
                        state_next = S_FETCH;
                    end
                end
            end
            S_FLUSH:
            begin
                if (stat.out_free)
                begin
                    cmd.flush  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== hdl/gbr_dp.sv =====
// ----------------------------------------------------------------------------
// gbr_dp
// Datapath: bitmap store, glyph table, cursor, glyph origin, bit scanner,
// held pixel and output register.
// ----------------------------------------------------------------------------
module gbr_dp #(
    parameter int BITMAP_BYTES     = 4096,
    parameter int GLYPH_COUNT      = 128,
    parameter int MAX_GLYPH_WIDTH  = 8,
    parameter int MAX_GLYPH_HEIGHT = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  gbr_pkg::dp_cmd_t                    cmd,
    output gbr_pkg::dp_stat_t                   stat,
    input  gbr_pkg::cfg_t                       cfg,
    input  logic [gbr_pkg::ADDR_W-1:0]          address,
    input  logic [gbr_pkg::BYTE_W-1:0]          byte_data,
    input  logic [gbr_pkg::OFFSET_W-1:0]        glyph_offset,
    input  logic [gbr_pkg::SIZE_W-1:0]          glyph_width,
    input  logic [gbr_pkg::SIZE_W-1:0]          glyph_height,
    input  logic [gbr_pkg::ADV_W-1:0]           glyph_advance,
    input  logic signed [gbr_pkg::DELTA_W-1:0]  glyph_dx,
    input  logic signed [gbr_pkg::DELTA_W-1:0]  glyph_dy,
    input  logic signed [gbr_pkg::COORD_W-1:0]  pos_x,
    input  logic signed [gbr_pkg::COORD_W-1:0]  pos_y,
    input  logic [gbr_pkg::CHAR_W-1:0]          char_code,
    gbr_out_if.source                           out_ch
);
    import gbr_pkg::*;

    localparam int BA_W = (BITMAP_BYTES > 1) ? $clog2(BITMAP_BYTES) : 1;
    localparam int RW   = (BA_W > OFFSET_W) ? BA_W : OFFSET_W;
    localparam int GI_W = (GLYPH_COUNT > 1) ? $clog2(GLYPH_COUNT) : 1;

    // stores
    logic [BYTE_W-1:0] bitmap_mem [BITMAP_BYTES];
    glyph_entry_t      glyph_mem  [GLYPH_COUNT];
    logic [BYTE_W-1:0] byte_rd_reg;
    glyph_entry_t      glyph_rd_reg;

    // draw state
    logic [COORD_W-1:0] cursor_x_reg;
    logic [COORD_W-1:0] cursor_y_reg;
    logic [COORD_W-1:0] nx_reg;
    logic [COORD_W-1:0] ox_reg;
    logic [COORD_W-1:0] oy_reg;
    logic [SIZE_W-1:0]  w_reg;
    logic [SIZE_W-1:0]  h_reg;
    logic [RW-1:0]      addr_reg;
    logic [2:0]         col_reg;
    logic [2:0]         row_reg;
    logic [2:0]         bpos_reg;
    logic               pend_valid_reg;
    logic [COORD_W-1:0] pend_x_reg;
    logic [COORD_W-1:0] pend_y_reg;

    // output register
    logic               out_valid_reg;
    logic [COORD_W-1:0] out_x_reg;
    logic [COORD_W-1:0] out_y_reg;
    logic [COLOR_W-1:0] out_color_reg;
    logic               out_pix_reg;
    logic               out_last_reg;
    logic [COORD_W-1:0] out_nx_reg;

    logic [CHAR_W-1:0]  char_diff;
    glyph_entry_t       glyph_wr;
    logic               bm_wr_ok;
    logic               gt_wr_ok;
    logic [SIZE_W-1:0]  w_sat;
    logic [SIZE_W-1:0]  h_sat;
    logic               col_end;
    logic               row_end;
    logic               push_mid;
    logic               push;

    // request decode
    assign char_diff = char_code - cfg.first_char;
    assign bm_wr_ok  = (32'(address) < BITMAP_BYTES);
    assign gt_wr_ok  = (32'(address) < GLYPH_COUNT);
    assign glyph_wr  = '{offset:  glyph_offset,
                         width:   glyph_width,
                         height:  glyph_height,
                         advance: glyph_advance,
                         dx:      glyph_dx,
                         dy:      glyph_dy};

    // glyph size saturation
    assign w_sat = (glyph_rd_reg.width > SIZE_W'(MAX_GLYPH_WIDTH))
                 ? SIZE_W'(MAX_GLYPH_WIDTH) : glyph_rd_reg.width;
    assign h_sat = (glyph_rd_reg.height > SIZE_W'(MAX_GLYPH_HEIGHT))
                 ? SIZE_W'(MAX_GLYPH_HEIGHT) : glyph_rd_reg.height;

    // scan position
    assign col_end  = ({1'b0, col_reg} + SIZE_W'(1)) == w_reg;
    assign row_end  = ({1'b0, row_reg} + SIZE_W'(1)) == h_reg;
    assign push_mid = cmd.scan_step && stat.bit_set && pend_valid_reg;
    assign push     = push_mid || cmd.flush;

    // status
    assign stat.code_hit   = (char_code >= cfg.first_char) &&
                             (char_code <= cfg.last_char) &&
                             (32'(char_diff) < GLYPH_COUNT);
    assign stat.size_zero  = (w_reg == '0) || (h_reg == '0);
    assign stat.addr_big   = (32'(addr_reg) >= BITMAP_BYTES);
    assign stat.bit_set    = byte_rd_reg[3'd7 - bpos_reg];
    assign stat.pend_valid = pend_valid_reg;
    assign stat.out_free   = !out_valid_reg || out_ch.ready;
    assign stat.scan_last  = col_end && row_end;
    assign stat.byte_end   = (bpos_reg == 3'd7);

    // bitmap store, one write and one registered read
    always_ff @(posedge clk)
    begin
        if (cmd.load_byte && bm_wr_ok)
        begin
            bitmap_mem[BA_W'(address)] <= byte_data;
        end
        if (cmd.fetch)
        begin
            byte_rd_reg <= bitmap_mem[BA_W'(addr_reg)];
        end
    end

    // glyph table, one write and one registered read
    always_ff @(posedge clk)
    begin
        if (cmd.load_glyph && gt_wr_ok)
        begin
            glyph_mem[GI_W'(address)] <= glyph_wr;
        end
        if (cmd.start_draw)
        begin
            glyph_rd_reg <= glyph_mem[GI_W'(char_diff)];
        end
    end

    // cursor
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_x_reg <= '0;
            cursor_y_reg <= '0;
        end
        else if (cmd.set_cursor)
        begin
            cursor_x_reg <= pos_x;
            cursor_y_reg <= pos_y;
        end
        else if (cmd.flush)
        begin
            cursor_x_reg <= nx_reg;
        end
    end

    // held pixel valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
        end
        else if (cmd.start_draw)
        begin
            pend_valid_reg <= 1'b0;
        end
        else if (cmd.scan_step && stat.bit_set)
        begin
            pend_valid_reg <= 1'b1;
        end
    end

    // glyph origin, counters and held pixel
    always_ff @(posedge clk)
    begin
        if (cmd.start_draw)
        begin
            nx_reg <= cursor_x_reg;
        end
        if (cmd.setup)
        begin
            nx_reg   <= cursor_x_reg + COORD_W'(glyph_rd_reg.advance);
            ox_reg   <= cursor_x_reg + {{(COORD_W-DELTA_W){glyph_rd_reg.dx[DELTA_W-1]}},
                                        glyph_rd_reg.dx};
            oy_reg   <= cursor_y_reg + {{(COORD_W-DELTA_W){glyph_rd_reg.dy[DELTA_W-1]}},
                                        glyph_rd_reg.dy}
                                     + COORD_W'(cfg.line_height);
            w_reg    <= w_sat;
            h_reg    <= h_sat;
            addr_reg <= RW'(glyph_rd_reg.offset);
            col_reg  <= '0;
            row_reg  <= '0;
            bpos_reg <= '0;
        end
        // offset wrap into the store
        if (cmd.reduce_step)
        begin
            addr_reg <= addr_reg - RW'(BITMAP_BYTES);
        end
        // one glyph bit per step
        if (cmd.scan_step)
        begin
            if (stat.bit_set)
            begin
                pend_x_reg <= ox_reg + COORD_W'(col_reg);
                pend_y_reg <= oy_reg + COORD_W'(row_reg);
            end
            if (col_end)
            begin
                col_reg <= '0;
                row_reg <= row_reg + 3'd1;
            end
            else
            begin
                col_reg <= col_reg + 3'd1;
            end
            bpos_reg <= bpos_reg + 3'd1;
            if (bpos_reg == 3'd7)
            begin
                addr_reg <= (32'(addr_reg) == BITMAP_BYTES - 1) ? '0 : addr_reg + RW'(1);
            end
        end
    end

    // output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (push)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            if (pend_valid_reg)
            begin
                out_x_reg     <= pend_x_reg;
                out_y_reg     <= pend_y_reg;
                out_color_reg <= cfg.text_color;
                out_pix_reg   <= 1'b1;
            end
            else
            begin
                out_x_reg     <= '0;
                out_y_reg     <= '0;
                out_color_reg <= '0;
                out_pix_reg   <= 1'b0;
            end
            out_last_reg <= cmd.flush;
            out_nx_reg   <= cmd.flush ? nx_reg : '0;
        end
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.pixel_x       = out_x_reg;
    assign out_ch.pixel_y       = out_y_reg;
    assign out_ch.pixel_color   = out_color_reg;
    assign out_ch.pixel_valid   = out_pix_reg;
    assign out_ch.last          = out_last_reg;
    assign out_ch.next_cursor_x = out_nx_reg;

endmodule

// ===== hdl/glyph_bitmap_rasterizer.sv =====
// ----------------------------------------------------------------------------
// glyph_bitmap_rasterizer
// Text blitter with its own packed bitmap font: loads, cursor placement and
// character drawing into a stream of pixel writes.
// ----------------------------------------------------------------------------
// loads and set cursor are done in idle and the next request follows directly; no other
// request is taken during a draw, which reads its glyph entry, sets up origin and box,
// brings the offset into the store, fetches each byte from the one bitmap read port
// and scans its bits in turn, then gives the final result (an empty box skips the scan,
// a miss goes straight to it); the scanner takes one bit per cycle while the result side
// has room for a waiting result; reset clears control, cursor and output valid and
// loads register defaults; bitmap store and glyph table hold nothing defined until written
module glyph_bitmap_rasterizer #(
    parameter int BITMAP_BYTES     = 4096,
    parameter int GLYPH_COUNT      = 128,
    parameter int MAX_GLYPH_WIDTH  = 8,
    parameter int MAX_GLYPH_HEIGHT = 8
) (
    input  logic                       clk,
    input  logic                       rst_n,
    gbr_in_if.sink                     in_ch,
    gbr_out_if.source                  out_ch,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [gbr_pkg::APB_AW-1:0] paddr,
    input  logic [gbr_pkg::APB_DW-1:0] pwdata,
    output logic [gbr_pkg::APB_DW-1:0] prdata,
    output logic                       pready
);
    import gbr_pkg::*;

    cfg_t     cfg;
    dp_cmd_t  cmd;
    dp_stat_t stat;

    // configuration registers
    gbr_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // controller
    gbr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_kind  (in_ch.kind),
        .in_ready (in_ch.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // datapath
    gbr_dp #(
        .BITMAP_BYTES     (BITMAP_BYTES),
        .GLYPH_COUNT      (GLYPH_COUNT),
        .MAX_GLYPH_WIDTH  (MAX_GLYPH_WIDTH),
        .MAX_GLYPH_HEIGHT (MAX_GLYPH_HEIGHT)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .cfg           (cfg),
        .address       (in_ch.address),
        .byte_data     (in_ch.byte_data),
        .glyph_offset  (in_ch.glyph_offset),
        .glyph_width   (in_ch.glyph_width),
        .glyph_height  (in_ch.glyph_height),
        .glyph_advance (in_ch.glyph_advance),
        .glyph_dx      (in_ch.glyph_dx),
        .glyph_dy      (in_ch.glyph_dy),
        .pos_x         (in_ch.pos_x),
        .pos_y         (in_ch.pos_y),
        .char_code     (in_ch.char_code),
        .out_ch        (out_ch)
    );

endmodule
